// File: rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int SQ_W     = 2 * SAMPLE_W;

    // accumulator and long-division widths
    localparam int SUM_W      = 47;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // square root: two radicand bits per step
    localparam int RAD_W      = 32;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SREM_W     = ROOT_W + 1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic accum;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/bpm_ctrl.sv
`default_nettype none

module bpm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output bpm_pkg::t_cmd      o_cmd,
    input  wire bpm_pkg::t_sts i_sts
);
    import bpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SQLD,
        ST_SQRT,
        ST_EMIT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_out_valid;
    logic                n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.accum     = (r_state == ST_ACC);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.sqrt_load = (r_state == ST_SQLD);
        o_cmd.sqrt_step = (r_state == ST_SQRT);
        o_cmd.out_load  = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_step = '0;
                if (i_sts.last) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SQLD;
                end
            end
            ST_SQLD: begin
                n_step  = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpm_dp.sv
`default_nettype none

module bpm_dp #(
    parameter int MAX_BLOCK = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpm_pkg::t_cmd                 i_cmd,
    output bpm_pkg::t_sts                      o_sts,
    input  wire logic [bpm_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_last,
    output logic [bpm_pkg::LEVEL_W-1:0]        o_rms,
    output logic [bpm_pkg::LEVEL_W-1:0]        o_peak,
    output logic                               o_ovf
);
    import bpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    // captured sample
    logic [SAMPLE_W-1:0] r_mag;
    logic [SQ_W-1:0]     r_sq;
    logic                r_last;
    logic [SAMPLE_W-1:0] n_mag;

    // block accumulators
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [SAMPLE_W-1:0] r_peak;
    logic                r_ovf;

    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_count;
    logic [SAMPLE_W-1:0] n_peak;
    logic                n_ovf;
    logic                count_full;

    // divider
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_dvs;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W:0]      rem_sh;
    logic                q_bit;

    // square root
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W-1:0]   r_root;
    logic [SREM_W-1:0]   r_srem;
    logic [SREM_W+1:0]   srem_sh;
    logic [SREM_W+1:0]   trial;
    logic                root_bit;

    // held results
    logic [SAMPLE_W-1:0] r_peak_res;
    logic                r_ovf_res;
    logic [LEVEL_W-1:0]  r_rms_out;
    logic [LEVEL_W-1:0]  r_peak_out;
    logic                r_ovf_out;

    assign o_sts.last = r_last;
    assign o_rms      = r_rms_out;
    assign o_peak     = r_peak_out;
    assign o_ovf      = r_ovf_out;

    // magnitude, most negative sample gives 32768
    assign n_mag = i_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - i_sample) : i_sample;

    // accumulate with saturating sum and count limit
    always_comb begin
        count_full = (r_count == CNT_W'(MAX_BLOCK));
        sum_add    = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
        n_peak     = (r_mag > r_peak) ? r_mag : r_peak;
        n_sum      = r_sum;
        n_count    = r_count;
        n_ovf      = r_ovf;
        if (count_full) begin
            n_ovf = 1'b1;
        end else begin
            n_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            n_count = r_count + CNT_W'(1);
        end
    end

    // one restoring division step
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
    end

    // one square root step
    always_comb begin
        srem_sh  = {r_srem, r_rad[RAD_W-1 -: 2]};
        trial    = {1'b0, r_root, 2'b01};
        root_bit = (srem_sh >= trial);
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mag  <= n_mag;
            r_sq   <= SQ_W'(n_mag) * SQ_W'(n_mag);
            r_last <= i_last;
        end
    end

    // accumulators, cleared at block end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accum) begin
            if (r_last) begin
                r_sum   <= '0;
                r_count <= '0;
                r_peak  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_peak  <= n_peak;
                r_ovf   <= n_ovf;
            end
        end
    end

    // divider: quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && r_last) begin
            r_quo      <= n_sum;
            r_dvs      <= n_count;
            r_rem      <= '0;
            r_peak_res <= n_peak;
            r_ovf_res  <= n_ovf;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= CNT_W'(rem_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
            end
        end
    end

    // integer square root, two bits a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_rad  <= (r_dvs == '0) ? '0 : r_quo[RAD_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], root_bit};
            if (root_bit) begin
                r_srem <= SREM_W'(srem_sh - trial);
            end else begin
                r_srem <= srem_sh[SREM_W-1:0];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rms_out  <= r_root;
            r_peak_out <= r_peak_res;
            r_ovf_out  <= r_ovf_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/block_rms_peak_meter_core.sv
`default_nettype none

// channel  | dir | tdata                          | tlast     | tuser
// ---------+-----+--------------------------------+-----------+---------------
// s_axis   | in  | [15:0] sample (signed)         | block_end | -
// m_axis   | out | [15:0] rms_level [31:16] peak  | -         | block_overflow
//
// a sample that does not end a block is captured, then accumulated; a block-ending
// sample then goes through 47 divide steps, a square-root load, 16 square-root steps
// and an output load; the 47-bit sum is divided bit-serially by the sample count
// synchronous active-low reset clears the accumulators, state and output valid
// a waiting output word does not block new samples; only a second block end
// waits for the output register to be taken

module block_rms_peak_meter_core #(
    parameter int MAX_BLOCK = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic        s_axis_tlast,   // block_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] rms_level, [31:16] peak_level
    output logic             m_axis_tuser    // block_overflow
);
    import bpm_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;

    // sequencer
    bpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // accumulators, divider and square root
    bpm_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_rms    (rms),
        .o_peak   (peak),
        .o_ovf    (m_axis_tuser)
    );

    assign m_axis_tdata = {peak, rms};

`ifndef SYNTHESIS
    // after taking a sample the block is not ready in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample accepted on back-to-back cycles");

    // rms never exceeds full scale
    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'h8000))
        else $error("rms level above full scale");

    // peak never exceeds full scale
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:16] <= 16'h8000))
        else $error("peak level above full scale");

    // a new output word appears only after a block end was taken in
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output word without block processing");
`endif

endmodule

`default_nettype wire

// File: tb/sv/block_rms_peak_meter_core_tb.sv
`default_nettype none

module block_rms_peak_meter_core_tb;

    localparam int              BLOCK_LIMIT    = 65536;
    localparam longint unsigned SUM_CEIL       = (64'd1 << 47) - 64'd1;
    localparam int              CYCLE_LIMIT    = 2_000_000;
    localparam int              DRAIN_CYCLES   = 100;
    localparam int              HOLD_CYCLES    = 2000;
    localparam int              FULL_BLOCK_LEN = 128;
    localparam int              PHASE_ITEMS    = 150;

    // directed samples as {block_end, sample}
    localparam logic [16:0] DIRECTED [16] = '{
        17'h10000, 17'h18000, 17'h17FFF, 17'h00001,
        17'h1FFFF, 17'h08001, 17'h07FFF, 17'h18000,
        17'h00003, 17'h10004, 17'h05555, 17'h0AAAA,
        17'h00000, 17'h10000, 17'h0FFFF, 17'h100FF
    };

    // one result word as the block reports it
    typedef struct packed {
        logic [15:0] rms;
        logic [15:0] peak;
        logic        ovf;
    } t_level_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] sample
    logic        s_axis_tlast  = 1'b0; // block_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] rms_level, [31:16] peak_level
    logic        m_axis_tuser;         // block_overflow

    // predictor state
    longint unsigned sq_total  = 0;
    int unsigned     counted   = 0;
    longint unsigned peak_mag  = 0;
    logic            over_flag = 1'b0;
    t_level_word     level_expect_q[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;
    int  hold_left      = 0;
    int  err_count      = 0;
    int  cycle_count    = 0;

    block_rms_peak_meter_core #(
        .MAX_BLOCK(BLOCK_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // floor of the square root, one result bit at a time
    function automatic logic [15:0] floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root[15:0];
    endfunction

    // update the meter state for one accepted sample, queue a word at block end
    task automatic meter_accept(input logic [15:0] smp, input logic last);
        longint unsigned mag;
        longint unsigned sq;
        t_level_word     w;
        mag = smp[15] ? (64'h10000 - smp) : smp;
        if (mag > peak_mag) peak_mag = mag;
        // samples past the bound only touch the peak and the flag
        if (counted >= BLOCK_LIMIT) begin
            over_flag = 1'b1;
        end else begin
            sq = mag * mag;
            if (sq_total > SUM_CEIL - sq) sq_total = SUM_CEIL;
            else sq_total += sq;
            counted++;
        end
        if (last) begin
            w.rms  = (counted != 0) ? floor_sqrt(sq_total / counted) : '0;
            w.peak = peak_mag[15:0];
            w.ovf  = over_flag;
            level_expect_q = {level_expect_q, w};
            sq_total  = 0;
            counted   = 0;
            peak_mag  = 0;
            over_flag = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // offer one sample, wait for the handshake, then predict
    task automatic send_sample(input logic [15:0] smp, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        meter_accept(smp, last);
    endtask

    // half extremes and small magnitudes, the other half full random
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return $urandom_range(1) ? 16'h0001 : 16'hFFFF;
            4: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random_block(input int len);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        for (int i = 0; i < 8; i++) send_sample(DIRECTED[i][15:0], DIRECTED[i][16]);
        set_idling(50, 50);
        for (int i = 8; i < 16; i++) send_sample(DIRECTED[i][15:0], DIRECTED[i][16]);
    endtask

    // long block of most negative samples: every square at full scale
    task automatic test_full_scale_block();
        set_idling(0, 0);
        for (int i = 0; i < FULL_BLOCK_LEN; i++) begin
            send_sample(16'h8000, i == FULL_BLOCK_LEN - 1);
        end
    endtask

    // receiver holds off while short blocks keep coming, so the input stalls
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) send_random_block($urandom_range(3, 1));
    endtask

    task automatic test_random_phases();
        int sent;
        int len;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(76, 0);
                2: set_idling(0, 76);
                default: set_idling(10, 10);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                send_random_block(len);
                sent += len;
            end
        end
    endtask

    // receiver ready, with random stalls and a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each accepted word with the oldest expected one
    always @(posedge i_clk) begin : check_words
        t_level_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (level_expect_q.size() == 0) begin
                report_mismatch("unexpected word, rms", m_axis_tdata[15:0], 0);
            end else begin
                want = level_expect_q.pop_front();
                if (m_axis_tdata[15:0] !== want.rms)
                    report_mismatch("rms_level", m_axis_tdata[15:0], want.rms);
                if (m_axis_tdata[31:16] !== want.peak)
                    report_mismatch("peak_level", m_axis_tdata[31:16], want.peak);
                if (m_axis_tuser !== want.ovf)
                    report_mismatch("block_overflow", m_axis_tuser, want.ovf);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL block_rms_peak_meter_core");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_scale_block();
        test_output_backpressure();
        test_random_phases();

        // drain the remaining words
        s_axis_tvalid <= 1'b0;
        set_idling(0, 0);
        @(posedge i_clk);
        while (level_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("PASS block_rms_peak_meter_core");
        end else begin
            $display("FAIL block_rms_peak_meter_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
